// ===== rtl/core/fgm_pkg.sv =====
// ----------------------------------------------------------------------------
// fgm_pkg
// Shared constants, widths and controller/datapath interface types for the
// feature gallery matcher.
// ----------------------------------------------------------------------------
package fgm_pkg;

	// Sizes of the query vector and the gallery
	localparam int FEAT_LEN    = 128;
	localparam int GAL_DEPTH   = 32;

	localparam int ELEM_W      = (FEAT_LEN > 1) ? $clog2(FEAT_LEN) : 1;
	localparam int ELEM_CNT_W  = $clog2(FEAT_LEN + 1);
	localparam int ENTRY_W     = (GAL_DEPTH > 1) ? $clog2(GAL_DEPTH) : 1;
	localparam int ENTRY_CNT_W = $clog2(GAL_DEPTH + 1);
	localparam int GMEM_DEPTH  = GAL_DEPTH << ELEM_W;

	// Field widths
	localparam int FEAT_W      = 16;
	localparam int PROD_W      = 2 * FEAT_W;
	localparam int ACC_W       = PROD_W + $clog2(FEAT_LEN) + 1;
	localparam int ID_W        = 32;
	localparam int FRAME_W     = 32;
	localparam int SLOT_W      = 5;
	localparam int THR_W       = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	// APB register map
	localparam int              PADDR_W     = 3;
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
	localparam logic [THR_W-1:0]   THRESHOLD_RST  = 32'd751619277;

	// Commands carried in tuser
	localparam logic CMD_MATCH = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic               take;        // input transaction accepted
		logic               score_init;  // load best score with threshold
		logic               rd_issue;    // read query (and gallery) element
		logic               rd_copy;     // read is for copying into gallery
		logic [ELEM_W-1:0]  elem;
		logic [ENTRY_W-1:0] entry;
		logic               rd_last;     // final element of this entry
		logic               slot_init;   // pick append slot, seed oldest search
		logic               search_step; // compare one last-seen frame
		logic               commit;      // load result, update tables
	} fgm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [ENTRY_CNT_W-1:0] entry_cnt;
		logic                   gal_full;
		logic                   out_free;
	} fgm_status_t;

endpackage

// ===== rtl/core/fgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgm_ctrl
// Sequencer for the matcher: collects elements, then walks scoring, oldest
// entry search, vector copy and result hand-off.
// ----------------------------------------------------------------------------
module fgm_ctrl
	import fgm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tlast,
	input  logic        s_tuser,
	output logic        s_tready,
	input  fgm_status_t status,
	output fgm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCORE,
		ST_DRAIN,
		ST_SEARCH,
		ST_COPY,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [ELEM_W-1:0]  elem_q;
	logic [ENTRY_W-1:0] entry_q;
	logic               drain_q;
	logic               take;
	logic               elem_last;
	logic               entry_last;

	assign s_tready   = (state_q == ST_IDLE);
	assign take       = s_tvalid && s_tready;
	assign elem_last  = (elem_q == ELEM_W'(FEAT_LEN - 1));
	assign entry_last = ((ENTRY_CNT_W'(entry_q) + ENTRY_CNT_W'(1)) == status.entry_cnt);

	// Decode commands from state and counters
	always_comb begin
		cmd             = '0;
		cmd.take        = take;
		cmd.elem        = elem_q;
		cmd.entry       = entry_q;
		cmd.rd_last     = elem_last;
		cmd.score_init  = take && s_tlast && (s_tuser == CMD_MATCH);
		cmd.slot_init   = take && s_tlast && (s_tuser == CMD_ADD);
		cmd.rd_issue    = (state_q == ST_SCORE) || (state_q == ST_COPY);
		cmd.rd_copy     = (state_q == ST_COPY);
		cmd.search_step = (state_q == ST_SEARCH);
		cmd.commit      = (state_q == ST_RESULT) && status.out_free;
	end

	// Hold state and advance counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			entry_q <= '0;
			drain_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					elem_q  <= '0;
					entry_q <= '0;
					drain_q <= 1'b0;
					if (take && s_tlast) begin
						if (s_tuser == CMD_ADD) begin
							if (status.gal_full && (GAL_DEPTH > 1)) begin
								entry_q <= ENTRY_W'(1);
								state_q <= ST_SEARCH;
							end else begin
								state_q <= ST_COPY;
							end
						end else if (status.entry_cnt == '0) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCORE;
						end
					end
				end
				ST_SCORE: begin
					if (elem_last) begin
						elem_q <= '0;
						if (entry_last) begin
							state_q <= ST_DRAIN;
						end else begin
							entry_q <= entry_q + ENTRY_W'(1);
						end
					end else begin
						elem_q <= elem_q + ELEM_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_RESULT;
					end
				end
				ST_SEARCH: begin
					if (entry_q == ENTRY_W'(GAL_DEPTH - 1)) begin
						state_q <= ST_COPY;
					end else begin
						entry_q <= entry_q + ENTRY_W'(1);
					end
				end
				ST_COPY: begin
					if (elem_last) begin
						state_q <= ST_RESULT;
					end else begin
						elem_q <= elem_q + ELEM_W'(1);
					end
				end
				ST_RESULT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/fgm_datapath.sv =====
// ----------------------------------------------------------------------------
// fgm_datapath
// Query and gallery stores, the dot product MAC pipeline, best and oldest
// trackers, identity tables and the result register.
// ----------------------------------------------------------------------------
module fgm_datapath
	import fgm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  fgm_cmd_t               cmd,
	output fgm_status_t            status,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	input  logic [THR_W-1:0]       threshold,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// Stores
	logic signed [FEAT_W-1:0] qbuf_mem [FEAT_LEN];
	logic signed [FEAT_W-1:0] gfeat_mem [GMEM_DEPTH];
	logic [ID_W-1:0]          ids_q [GAL_DEPTH];
	logic [FRAME_W-1:0]       seen_q [GAL_DEPTH];

	// Vector collection
	logic [ELEM_CNT_W-1:0] elem_cnt_q;
	logic [ELEM_CNT_W-1:0] elem_cnt_nx;
	logic [ELEM_CNT_W-1:0] qlen_q;
	logic [FRAME_W-1:0]    frame_q;
	logic                  cmd_q;
	logic                  in_room;

	// Gallery bookkeeping
	logic [ENTRY_CNT_W-1:0] entry_cnt_q;
	logic [ID_W-1:0]        next_id_q;
	logic [ENTRY_W-1:0]     wslot_q;
	logic [FRAME_W-1:0]     oldest_q;

	// MAC pipeline
	logic signed [FEAT_W-1:0] q_s1;
	logic signed [FEAT_W-1:0] g_s1;
	logic                     score_s1;
	logic                     copy_s1;
	logic                     mask_s1;
	logic                     last_s1;
	logic [ENTRY_W-1:0]       entry_s1;
	logic [ELEM_W-1:0]        elem_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     score_s2;
	logic                     last_s2;
	logic [ENTRY_W-1:0]       entry_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  best_q;
	logic [ENTRY_W-1:0]       best_slot_q;
	logic                     hit_q;

	// Result register
	logic               out_valid_q;
	logic               found_q;
	logic [ID_W-1:0]    pid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               repl_q;

	assign in_room     = (elem_cnt_q < ELEM_CNT_W'(FEAT_LEN));
	assign elem_cnt_nx = in_room ? (elem_cnt_q + ELEM_CNT_W'(1)) : elem_cnt_q;
	assign acc_sum     = acc_q + ACC_W'(prod_s2);

	assign status.entry_cnt = entry_cnt_q;
	assign status.gal_full  = (entry_cnt_q == ENTRY_CNT_W'(GAL_DEPTH));
	assign status.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, repl_q, slot_q, pid_q, found_q};

	// Count arriving elements, latch vector length and frame on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			qlen_q     <= '0;
		end else if (cmd.take) begin
			if (s_tlast) begin
				elem_cnt_q <= '0;
				qlen_q     <= elem_cnt_nx;
			end else begin
				elem_cnt_q <= elem_cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && s_tlast) begin
			frame_q <= s_tdata[IN_TDATA_W-1:FEAT_W];
			cmd_q   <= s_tuser;
		end
	end

	// Query buffer: write arriving element, read for scoring or copy
	always_ff @(posedge clk) begin
		if (cmd.take && in_room) begin
			qbuf_mem[elem_cnt_q[ELEM_W-1:0]] <= s_tdata[FEAT_W-1:0];
		end
		q_s1 <= qbuf_mem[cmd.elem];
	end

	// Gallery features: copy write in the cycle after the query read
	always_ff @(posedge clk) begin
		if (copy_s1) begin
			gfeat_mem[{wslot_q, elem_s1}] <= mask_s1 ? q_s1 : '0;
		end
		g_s1 <= gfeat_mem[{cmd.entry, cmd.elem}];
	end

	// Stage 1 tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_s1 <= 1'b0;
			copy_s1  <= 1'b0;
		end else begin
			score_s1 <= cmd.rd_issue && !cmd.rd_copy;
			copy_s1  <= cmd.rd_issue && cmd.rd_copy;
		end
	end

	always_ff @(posedge clk) begin
		mask_s1  <= (ELEM_CNT_W'(cmd.elem) < qlen_q);
		last_s1  <= cmd.rd_last;
		entry_s1 <= cmd.entry;
		elem_s1  <= cmd.elem;
	end

	// Stage 2: one product, zero past the received length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_s2 <= 1'b0;
		end else begin
			score_s2 <= score_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= mask_s1 ? (PROD_W'(q_s1) * PROD_W'(g_s1)) : '0;
		last_s2  <= last_s1;
		entry_s2 <= entry_s1;
	end

	// Accumulate and keep the best score strictly above the threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.score_init) begin
			acc_q <= '0;
			hit_q <= 1'b0;
		end else if (score_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				if (acc_sum > best_q) begin
					hit_q <= 1'b1;
				end
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.score_init) begin
			best_q <= ACC_W'(signed'(threshold));
		end else if (score_s2 && last_s2 && (acc_sum > best_q)) begin
			best_q      <= acc_sum;
			best_slot_q <= entry_s2;
		end
	end

	// Pick the write slot: append, or find the first smallest last-seen frame
	always_ff @(posedge clk) begin
		if (cmd.slot_init) begin
			oldest_q <= seen_q[0];
			wslot_q  <= status.gal_full ? '0 : entry_cnt_q[ENTRY_W-1:0];
		end else if (cmd.search_step && (seen_q[cmd.entry] < oldest_q)) begin
			oldest_q <= seen_q[cmd.entry];
			wslot_q  <= cmd.entry;
		end
	end

	// Update identity and last-seen tables on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (cmd_q == CMD_ADD) begin
				ids_q[wslot_q]  <= next_id_q;
				seen_q[wslot_q] <= frame_q;
			end else if (hit_q) begin
				seen_q[best_slot_q] <= frame_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q <= '0;
			next_id_q   <= '0;
		end else if (cmd.commit && (cmd_q == CMD_ADD)) begin
			next_id_q <= next_id_q + ID_W'(1);
			if (!status.gal_full) begin
				entry_cnt_q <= entry_cnt_q + ENTRY_CNT_W'(1);
			end
		end
	end

	// Result register: load on commit, drop on output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (cmd_q == CMD_ADD) begin
				found_q <= 1'b1;
				pid_q   <= next_id_q;
				slot_q  <= SLOT_W'(wslot_q);
				repl_q  <= status.gal_full;
			end else begin
				found_q <= hit_q;
				pid_q   <= hit_q ? ids_q[best_slot_q] : '0;
				slot_q  <= hit_q ? SLOT_W'(best_slot_q) : '0;
				repl_q  <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/feature_gallery_matcher_top.sv =====
// ----------------------------------------------------------------------------
// feature_gallery_matcher_top
// Nearest-neighbour identity lookup by dot product over a stored gallery.
//
// Channel  Dir  Signals                         Carries
// s_*      in   tvalid tready tdata tuser tlast one vector element
// m_*      out  tvalid tready tdata             match or add result
// APB      in   psel penable pwrite paddr ...   match_threshold at 0x0
//
// Elements are taken one per cycle while the controller is idle. After the
// last element a match runs one MAC per cycle over the stored entries. An
// add copies the vector into a slot, after an oldest-entry search when the
// gallery is full. The datapath has a single MAC and one gallery read port.
// No clearing pass after reset. Elements are taken while a result waits in
// the output register; a new result waits for m_tready.
// ----------------------------------------------------------------------------
module feature_gallery_matcher_top
	import fgm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] feature_value, [47:16] frame_number
	input  logic                   s_tuser,  // command
	input  logic                   s_tlast,  // last_element
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // found, ident, slot, replaced, pad
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [THR_W-1:0]       pwdata,
	output logic [THR_W-1:0]       prdata,
	output logic                   pready
);

	fgm_cmd_t         cmd;
	fgm_status_t      status;
	logic [THR_W-1:0] threshold_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_THRESHOLD) ? threshold_q : '0;

	// Configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
		end else if (psel && penable && pwrite && (paddr == ADDR_THRESHOLD)) begin
			threshold_q <= pwdata;
		end
	end

	fgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fgm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.threshold (threshold_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feature gallery matcher. Vectors are streamed
// one element per transaction. A behavioural gallery model predicts every
// match or add outcome, and each result is checked field by field. A short
// directed table runs first. Random phases follow, each with its own
// threshold; most have random gaps on both streams, one a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import fgm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LIMIT_CYCLES = 2000000;
	localparam int  HOLD_CYCLES  = 30000;
	localparam int  DRAIN_CYCLES = 200;
	localparam int  PHASE_ITEMS  = 160;
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

	typedef struct packed {
		logic        found;
		logic [31:0] ident;
		logic [4:0]  slot;
		logic        replaced;
	} outcome_t;

	typedef struct {
		logic        cmd;
		logic [15:0] value;
		logic        last;
		logic [31:0] frame;
		logic        typed;
		outcome_t    outcome;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [15:0] feature_value, [47:16] frame_number
	logic                   s_tuser;   // command
	logic                   s_tlast;   // last_element
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [0] found, [32:1] ident, [37:33] slot, [38] replaced
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [THR_W-1:0]       pwdata;
	logic [THR_W-1:0]       prdata;
	logic                   pready;

	// Gallery model state
	logic signed [15:0] qbuf [FEAT_LEN];
	int                 qcount;
	logic signed [15:0] gal_feat [GAL_DEPTH][FEAT_LEN];
	logic [31:0]        gal_id   [GAL_DEPTH];
	logic [31:0]        gal_seen [GAL_DEPTH];
	int                 gal_count;
	logic [31:0]        next_pid;
	logic signed [31:0] threshold;

	outcome_t pending_outcomes[$];
	dir_row_t dir_rows[$];

	int  errors;
	int  cycles;
	int  n_vectors, n_hits, n_misses, n_adds, n_evictions, n_items;
	bit  hold_request;
	bit  send_steady, recv_steady;

	feature_gallery_matcher_top u_top (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, pending_outcomes.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the gallery model by one element; a last element yields an outcome
	task automatic model_element(input logic cmd, input logic signed [15:0] v,
		input logic last, input logic [31:0] frame, output bit has, output outcome_t o);
		longint best, score;
		bit     hit;
		int     win;
		logic [31:0] oldest;
		has = 0;
		o = '0;
		if (qcount < FEAT_LEN) begin
			qbuf[qcount] = v;
			qcount++;
		end
		if (!last) return;
		for (int j = qcount; j < FEAT_LEN; j++) qbuf[j] = '0;
		qcount = 0;
		has = 1;
		n_vectors++;
		if (cmd == CMD_MATCH) begin
			best = longint'(threshold);
			hit = 0;
			win = 0;
			for (int i = 0; i < gal_count; i++) begin
				score = 0;
				for (int j = 0; j < FEAT_LEN; j++)
					score += longint'(qbuf[j]) * longint'(gal_feat[i][j]);
				if (score > best) begin
					best = score;
					win = i;
					hit = 1;
				end
			end
			if (hit) begin
				gal_seen[win] = frame;
				o.found = 1'b1;
				o.ident = gal_id[win];
				o.slot = 5'(win);
				n_hits++;
			end else begin
				n_misses++;
			end
		end else begin
			if (gal_count >= GAL_DEPTH) begin
				oldest = gal_seen[0];
				win = 0;
				for (int i = 1; i < GAL_DEPTH; i++)
					if (gal_seen[i] < oldest) begin
						oldest = gal_seen[i];
						win = i;
					end
				o.replaced = 1'b1;
				n_evictions++;
			end else begin
				win = gal_count;
				gal_count++;
			end
			for (int j = 0; j < FEAT_LEN; j++) gal_feat[win][j] = qbuf[j];
			gal_id[win] = next_pid;
			gal_seen[win] = frame;
			o.found = 1'b1;
			o.ident = next_pid;
			o.slot = 5'(win);
			next_pid = next_pid + 1;
			n_adds++;
		end
	endtask

	// Offer one element, wait for its transaction, then record what it should cause
	task automatic send_element(input logic cmd, input logic [15:0] v, input logic last,
		input logic [31:0] frame, input logic typed, input outcome_t typed_o);
		bit       has;
		outcome_t o;
		int       gap;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tlast  <= last;
		s_tdata  <= {frame, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
		model_element(cmd, v, last, frame, has, o);
		if (has) pending_outcomes.push_back(typed ? typed_o : o);
		gap = send_steady ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_THRESHOLD) threshold = data;
	endtask

	task automatic apb_check(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== want) report("threshold readback", prdata, want);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Hold until every outcome is back and the block has gone quiet
	task automatic wait_idle();
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [31:0] value);
		wait_idle();
		apb_write(ADDR_THRESHOLD, value);
		apb_check(ADDR_THRESHOLD, value);
	endtask

	function automatic logic [15:0] rand_feature();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random vectors: adds, near copies of stored entries, and arbitrary queries
	task automatic random_phase(input int n);
		int          start_items, len, src;
		logic        cmd, similar;
		logic [15:0] v;
		logic [31:0] frame, fcount;
		int          noisy;
		start_items = n_items;
		fcount = $urandom_range(0, 1000);
		while (n_items - start_items < n) begin
			cmd = (gal_count == 0 || $urandom_range(0, 99) < 45) ? CMD_ADD : CMD_MATCH;
			case ($urandom_range(0, 19))
				0:       len = $urandom_range(120, 140);
				1, 2:    len = $urandom_range(17, 64);
				default: len = $urandom_range(1, 16);
			endcase
			similar = (cmd == CMD_MATCH) && ($urandom_range(0, 99) < 65);
			src = (gal_count > 0) ? $urandom_range(0, gal_count - 1) : 0;
			fcount = fcount + $urandom_range(0, 3);
			frame = ($urandom_range(0, 9) == 0) ? $urandom : fcount;
			for (int k = 0; k < len; k++) begin
				if (similar && k < FEAT_LEN) begin
					noisy = int'(gal_feat[src][k]) + $urandom_range(0, 64) - 32;
					if (noisy > 32767) noisy = 32767;
					if (noisy < -32768) noisy = -32768;
					v = 16'(noisy);
				end else begin
					v = rand_feature();
				end
				// command on non-last elements is ignored, so let it wander
				send_element((k == len - 1) ? cmd : logic'($urandom_range(0, 1)), v,
					k == len - 1, (k == len - 1) ? frame : $urandom, 1'b0, '0);
			end
		end
	endtask

	function automatic outcome_t mk(input logic f, input int pid, input int sl);
		outcome_t o;
		o.found = f;
		o.ident = pid;
		o.slot = 5'(sl);
		o.replaced = 1'b0;
		return o;
	endfunction

	task automatic add_row(input logic cmd, input logic [15:0] v, input logic last,
		input logic [31:0] frame, input logic typed, input outcome_t o);
		dir_row_t r;
		r.cmd = cmd;
		r.value = v;
		r.last = last;
		r.frame = frame;
		r.typed = typed;
		r.outcome = o;
		dir_rows.push_back(r);
	endtask

	// Result checker with random back-pressure and one long hold-off on request
	initial begin : result_check
		int       idle_left, hold_left;
		outcome_t got, want;
		m_tready = 1'b0;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.found     = m_tdata[0];
				got.ident     = m_tdata[32:1];
				got.slot      = m_tdata[37:33];
				got.replaced  = m_tdata[38];
				if (pending_outcomes.size() == 0) begin
					errors++;
					$display("[%0t] MISMATCH unexpected result 0x%0h", $realtime, m_tdata);
				end else begin
					want = pending_outcomes.pop_front();
					if (got.found !== want.found) report("found", got.found, want.found);
					if (got.ident !== want.ident)
						report("ident", got.ident, want.ident);
					if (got.slot !== want.slot) report("slot", got.slot, want.slot);
					if (got.replaced !== want.replaced)
						report("replaced", got.replaced, want.replaced);
				end
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!recv_steady) idle_left = gap_len();
			end
		end
	end

	// Stimulus
	initial begin
		logic [31:0] thr_values [5];
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		errors = 0;
		cycles = 0;
		qcount = 0;
		gal_count = 0;
		next_pid = '0;
		threshold = THRESHOLD_RST;
		hold_request = 0;
		send_steady = 0;
		recv_steady = 0;
		for (int j = 0; j < FEAT_LEN; j++) qbuf[j] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty gallery, extremes, short vectors, ignored command bits
		add_row(CMD_MATCH, 16'h7fff, 1, 32'd5,        1, mk(0, 0, 0));
		add_row(CMD_ADD,   16'h8000, 0, 32'd0,        0, '0);
		add_row(CMD_ADD,   16'h7fff, 0, 32'd0,        0, '0);
		add_row(CMD_ADD,   16'h0000, 1, 32'hffffffff, 1, mk(1, 0, 0));
		add_row(CMD_MATCH, 16'h8000, 0, 32'd0,        0, '0);
		add_row(CMD_MATCH, 16'h7fff, 0, 32'd0,        0, '0);
		add_row(CMD_MATCH, 16'h0000, 1, 32'd0,        0, '0);
		add_row(CMD_ADD,   16'hffff, 1, 32'd1,        1, mk(1, 1, 1));
		add_row(CMD_ADD,   16'hffff, 0, 32'hffffffff, 0, '0);
		add_row(CMD_MATCH, 16'h8000, 1, 32'd2,        0, '0);
		add_row(CMD_ADD,   16'h4000, 0, 32'd0,        0, '0);
		add_row(CMD_ADD,   16'hc000, 1, 32'd3,        1, mk(1, 2, 2));
		add_row(CMD_MATCH, 16'h0000, 1, 32'd4,        1, mk(0, 0, 0));
		add_row(CMD_MATCH, 16'h4000, 0, 32'd0,        0, '0);
		add_row(CMD_MATCH, 16'hc000, 1, 32'h80000000, 0, '0);
		foreach (dir_rows[i])
			send_element(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].last,
				dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].outcome);

		// Unmapped register: write must leave the threshold alone
		wait_idle();
		apb_write(ADDR_UNMAPPED, 32'h12345678);
		apb_check(ADDR_THRESHOLD, THRESHOLD_RST);

		thr_values[0] = 32'h80000000;
		thr_values[1] = 32'h00000000;
		thr_values[2] = 32'h7fffffff;
		thr_values[3] = $urandom_range(0, 32'h7fffffff);
		thr_values[4] = THRESHOLD_RST;
		for (int p = 0; p < 5; p++) begin
			set_threshold(thr_values[p]);
			send_steady = (p == 3);
			recv_steady = (p == 4);
			if (p == 1) hold_request = 1;
			random_phase(PHASE_ITEMS);
		end

		@(posedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d elements forming %0d vectors over %0d cycles",
			n_items, n_vectors, cycles);
		$display("Matches hit %0d, missed %0d; adds %0d with %0d evictions",
			n_hits, n_misses, n_adds, n_evictions);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/fgm_pkg.sv
rtl/core/fgm_ctrl.sv
rtl/core/fgm_datapath.sv
rtl/core/feature_gallery_matcher_top.sv
verif/tb_top.sv
